// ----- rtl/ppmd_pkg.sv -----
package ppmd_pkg;

	// Width of the dimension accumulators and position counters (8 to 16)
	localparam int DIM_BITS = 16;
	// Width of the dimension and position fields of a result word
	localparam int OUT_DIM_W = 16;

	localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

	localparam logic [7:0] CH_P        = 8'h50;
	localparam logic [7:0] CH_SIX      = 8'h36;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] ALPHA_RESET = 8'hFF;

	localparam logic [1:0] MAGIC_LAST_IDX = 2'd2;

	typedef enum logic [2:0] {
		PH_MAGIC   = 3'd0,
		PH_FIRST   = 3'd1,
		PH_COMMENT = 3'd2,
		PH_WIDTH   = 3'd3,
		PH_HEIGHT  = 3'd4,
		PH_MAXVAL  = 3'd5,
		PH_PIXELS  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL     = 2'd0,
		KIND_HEADER    = 2'd1,
		KIND_BAD_MAGIC = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic [7:0]            alpha;
		logic [OUT_DIM_W-1:0]  column;
		logic [OUT_DIM_W-1:0]  row;
		logic [OUT_DIM_W-1:0]  width;
		logic [OUT_DIM_W-1:0]  height;
		logic                  last;
	} result_t;

endpackage

// ----- rtl/ppm_p6_stream_decoder_core.sv -----
// Each result word is registered into an output register backed by a skid stage;
// it goes into the skid stage while the output is stalled. One byte per cycle while
// in_stall is low; the parser updates its state in the same cycle a byte is accepted.
// in_stall rises only while the skid stage holds a word.
// Reset (arst_n low): parser back to the magic check, counters cleared,
// alpha register set to 255, output and skid stages empty.
module ppm_p6_stream_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            cfg_wr_en,
	input  logic [7:0]                      cfg_wr_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      result_kind,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic [7:0]                      alpha,
	output logic [ppmd_pkg::OUT_DIM_W-1:0]  column,
	output logic [ppmd_pkg::OUT_DIM_W-1:0]  row,
	output logic [ppmd_pkg::OUT_DIM_W-1:0]  image_width,
	output logic [ppmd_pkg::OUT_DIM_W-1:0]  image_height,
	output logic                            last_pixel
);
	import ppmd_pkg::*;

	logic    take;
	logic    pop;
	logic    new_v;
	result_t res;
	logic    res_valid;
	result_t out_q;
	logic    out_v_q;
	result_t skid_q;
	logic    skid_v_q;

	assign in_stall = skid_v_q;
	assign take     = in_valid && !skid_v_q;
	assign pop      = out_v_q && !out_stall;
	assign new_v    = take && res_valid;

	ppmd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res         (res),
		.res_valid   (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// no byte is taken while the skid stage is full
			if (pop) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= new_v;
		end else if (new_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (!out_v_q || pop) begin
			if (new_v)
				out_q <= res;
		end else if (new_v) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign result_kind  = out_q.kind;
	assign red          = out_q.red;
	assign green        = out_q.green;
	assign blue         = out_q.blue;
	assign alpha        = out_q.alpha;
	assign column       = out_q.column;
	assign row          = out_q.row;
	assign image_width  = out_q.width;
	assign image_height = out_q.height;
	assign last_pixel   = out_q.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full with output stage empty");

	a_pixel_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == KIND_PIXEL)
		|-> (out_q.column < out_q.width && out_q.row < out_q.height))
		else $error("pixel position outside the parsed frame");

	a_last_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == KIND_PIXEL && out_q.last)
		|-> (out_q.column == out_q.width - 1'b1 && out_q.row == out_q.height - 1'b1))
		else $error("last pixel flagged away from the final position");

	a_stall_holds_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_stall) |=> (skid_v_q && $stable(skid_q)))
		else $error("skid word lost while the output is stalled");

endmodule

// ----- rtl/ppmd_parser.sv -----
module ppmd_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             data_byte,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	output ppmd_pkg::result_t      res,
	output logic                   res_valid
);
	import ppmd_pkg::*;

	typedef struct packed {
		logic                closed;
		logic [DIM_BITS-1:0] acc;
	} num_t;

	// One decimal digit into an accumulator; a non-digit closes the number
	function automatic num_t add_digit(input logic [DIM_BITS-1:0] acc, input logic [7:0] b,
			input logic closed);
		num_t                r;
		logic [DIM_BITS+3:0] v;
		r.closed = closed;
		r.acc    = acc;
		v        = '0;
		if (!closed) begin
			if (b < CH_ZERO || b > CH_NINE) begin
				r.closed = 1'b1;
			end else begin
				v = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
					+ (DIM_BITS+4)'(b - CH_ZERO);
				r.acc = (v > (DIM_BITS+4)'(DIM_MAX)) ? DIM_MAX : v[DIM_BITS-1:0];
			end
		end
		return r;
	endfunction

	phase_t              phase_q, phase_n;
	logic [1:0]          mi_q, mi_n;
	logic                mm_q, mm_n;
	logic [DIM_BITS-1:0] w_q, w_n;
	logic [DIM_BITS-1:0] h_q, h_n;
	logic [1:0]          bip_q, bip_n;
	logic [7:0]          red_q, red_n;
	logic [7:0]          green_q, green_n;
	logic [DIM_BITS-1:0] col_q, col_n;
	logic [DIM_BITS-1:0] row_q, row_n;
	logic                closed_q, closed_n;
	logic [7:0]          alpha_q;

	logic [1:0]          mi_eff;
	logic                mm_eff;
	logic                mm_hit;
	logic                magic_end;
	logic                col_end;
	logic                row_end;
	logic                last;
	num_t                w_dig;
	num_t                h_dig;

	// an unused phase code restarts the magic check at index 0
	assign mi_eff    = (phase_q == PH_MAGIC) ? mi_q : 2'd0;
	assign mm_eff    = (phase_q == PH_MAGIC) ? mm_q : 1'b0;
	assign mm_hit    = mm_eff || (mi_eff == 2'd0 && data_byte != CH_P)
		|| (mi_eff == 2'd1 && data_byte != CH_SIX);
	assign magic_end = (mi_eff >= MAGIC_LAST_IDX);

	assign col_end = ({1'b0, col_q} + 1'b1) >= {1'b0, w_q};
	assign row_end = ({1'b0, row_q} + 1'b1) >= {1'b0, h_q};
	assign last    = col_end && row_end;

	assign w_dig = add_digit(w_q, data_byte, closed_q);
	assign h_dig = add_digit(h_q, data_byte, closed_q);

	always_comb begin
		phase_n  = phase_q;
		mi_n     = mi_q;
		mm_n     = mm_q;
		w_n      = w_q;
		h_n      = h_q;
		bip_n    = bip_q;
		red_n    = red_q;
		green_n  = green_q;
		col_n    = col_q;
		row_n    = row_q;
		closed_n = closed_q;
		case (phase_q)
			PH_FIRST: begin
				if (data_byte == CH_HASH) begin
					phase_n = PH_COMMENT;
				end else begin
					w_n      = w_dig.acc;
					closed_n = w_dig.closed;
					phase_n  = PH_WIDTH;
				end
			end
			PH_COMMENT: begin
				if (data_byte == CH_LF)
					phase_n = PH_FIRST;
			end
			PH_WIDTH: begin
				if (data_byte == CH_SPACE) begin
					closed_n = 1'b0;
					phase_n  = PH_HEIGHT;
				end else begin
					w_n      = w_dig.acc;
					closed_n = w_dig.closed;
				end
			end
			PH_HEIGHT: begin
				if (data_byte == CH_LF) begin
					closed_n = 1'b0;
					phase_n  = PH_MAXVAL;
				end else begin
					h_n      = h_dig.acc;
					closed_n = h_dig.closed;
				end
			end
			PH_MAXVAL: begin
				if (data_byte == CH_LF) begin
					col_n   = '0;
					row_n   = '0;
					bip_n   = 2'd0;
					mi_n    = 2'd0;
					mm_n    = 1'b0;
					phase_n = (w_q == '0 || h_q == '0) ? PH_MAGIC : PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (bip_q == 2'd0) begin
					red_n = data_byte;
					bip_n = 2'd1;
				end else if (bip_q == 2'd1) begin
					green_n = data_byte;
					bip_n   = 2'd2;
				end else begin
					bip_n = 2'd0;
					if (last) begin
						phase_n = PH_MAGIC;
						mi_n    = 2'd0;
						mm_n    = 1'b0;
						col_n   = '0;
						row_n   = '0;
					end else if (col_end) begin
						col_n = '0;
						row_n = row_q + 1'b1;
					end else begin
						col_n = col_q + 1'b1;
					end
				end
			end
			default: begin
				phase_n = PH_MAGIC;
				if (!magic_end) begin
					mi_n = mi_eff + 2'd1;
					mm_n = mm_hit;
				end else begin
					mi_n = 2'd0;
					mm_n = 1'b0;
					if (!mm_hit) begin
						w_n      = '0;
						h_n      = '0;
						closed_n = 1'b0;
						phase_n  = PH_FIRST;
					end
				end
			end
		endcase
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		case (phase_q)
			PH_FIRST, PH_COMMENT, PH_WIDTH, PH_HEIGHT: begin
				res_valid = 1'b0;
			end
			PH_MAXVAL: begin
				if (data_byte == CH_LF) begin
					res_valid  = 1'b1;
					res.kind   = KIND_HEADER;
					res.width  = OUT_DIM_W'(w_q);
					res.height = OUT_DIM_W'(h_q);
				end
			end
			PH_PIXELS: begin
				if (bip_q[1]) begin
					res_valid  = 1'b1;
					res.kind   = KIND_PIXEL;
					res.red    = red_q;
					res.green  = green_q;
					res.blue   = data_byte;
					res.alpha  = alpha_q;
					res.column = OUT_DIM_W'(col_q);
					res.row    = OUT_DIM_W'(row_q);
					res.width  = OUT_DIM_W'(w_q);
					res.height = OUT_DIM_W'(h_q);
					res.last   = last;
				end
			end
			default: begin
				if (magic_end && mm_hit) begin
					res_valid = 1'b1;
					res.kind  = KIND_BAD_MAGIC;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			mi_q     <= 2'd0;
			mm_q     <= 1'b0;
			w_q      <= '0;
			h_q      <= '0;
			bip_q    <= 2'd0;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			col_q    <= '0;
			row_q    <= '0;
			closed_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_n;
			mi_q     <= mi_n;
			mm_q     <= mm_n;
			w_q      <= w_n;
			h_q      <= h_n;
			bip_q    <= bip_n;
			red_q    <= red_n;
			green_q  <= green_n;
			col_q    <= col_n;
			row_q    <= row_n;
			closed_q <= closed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_wr_en) begin
			alpha_q <= cfg_wr_data;
		end
	end

endmodule

// ----- tb/sv/tb_ppm_p6_stream_decoder_core.sv -----
`timescale 1ns / 100ps

module tb_ppm_p6_stream_decoder_core;
	import ppmd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned MAX_REPORTS = 10;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           data_byte;
	logic                 cfg_wr_en;
	logic [7:0]           cfg_wr_data;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           result_kind;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic [OUT_DIM_W-1:0] column;
	logic [OUT_DIM_W-1:0] row;
	logic [OUT_DIM_W-1:0] image_width;
	logic [OUT_DIM_W-1:0] image_height;
	logic                 last_pixel;

	// decoder shadow state
	phase_t              ph         = PH_MAGIC;
	logic [1:0]          mg_idx     = '0;
	logic                mg_bad     = 1'b0;
	logic                num_closed = 1'b0;
	logic [DIM_BITS-1:0] w_acc      = '0;
	logic [DIM_BITS-1:0] h_acc      = '0;
	logic [DIM_BITS-1:0] col_cnt    = '0;
	logic [DIM_BITS-1:0] row_cnt    = '0;
	logic [1:0]          px_byte    = '0;
	logic [7:0]          r_hold     = '0;
	logic [7:0]          g_hold     = '0;
	logic [7:0]          alpha_reg  = ALPHA_RESET;

	result_t pending_words[$];

	int unsigned n_bytes   = 0;
	int unsigned n_pixels  = 0;
	int unsigned n_headers = 0;
	int unsigned n_bad     = 0;
	int unsigned n_images  = 0;
	int unsigned err_cnt   = 0;
	int unsigned cycle_cnt = 0;
	int unsigned mid_alpha = 0;

	// sender bursts and receiver stall pattern
	int unsigned burst_left = 0;
	bit          idle_on    = 1'b0;
	int unsigned stall_pct  = 0;
	int unsigned stall_run  = 0;
	bit          stall_now  = 1'b0;

	ppm_p6_stream_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.column       (column),
		.row          (row),
		.image_width  (image_width),
		.image_height (image_height),
		.last_pixel   (last_pixel)
	);

	always #10 clk = ~clk;

	function automatic logic [DIM_BITS-1:0] dim_digit(input logic [DIM_BITS-1:0] acc,
			input logic [7:0] b);
		int unsigned v;
		if (num_closed)
			return acc;
		if (b < CH_ZERO || b > CH_NINE) begin
			num_closed = 1'b1;
			return acc;
		end
		v = 32'(acc) * 10 + 32'(b) - 32'(CH_ZERO);
		if (v > 32'(DIM_MAX))
			v = 32'(DIM_MAX);
		return v[DIM_BITS-1:0];
	endfunction

	// advance the shadow decoder by one byte, queue any word it yields
	function automatic void decode_byte(input logic [7:0] b);
		result_t     res;
		int unsigned c_next;
		int unsigned r_next;
		bit          done;
		res = '0;
		c_next = 32'(col_cnt) + 1;
		r_next = 32'(row_cnt) + 1;
		case (ph)
		PH_FIRST: begin
			if (b == CH_HASH) begin
				ph = PH_COMMENT;
			end else begin
				w_acc = dim_digit(w_acc, b);
				ph = PH_WIDTH;
			end
		end
		PH_COMMENT: begin
			if (b == CH_LF)
				ph = PH_FIRST;
		end
		PH_WIDTH: begin
			if (b == CH_SPACE) begin
				num_closed = 1'b0;
				ph = PH_HEIGHT;
			end else begin
				w_acc = dim_digit(w_acc, b);
			end
		end
		PH_HEIGHT: begin
			if (b == CH_LF) begin
				num_closed = 1'b0;
				ph = PH_MAXVAL;
			end else begin
				h_acc = dim_digit(h_acc, b);
			end
		end
		PH_MAXVAL: begin
			if (b == CH_LF) begin
				res.kind = KIND_HEADER;
				res.width = w_acc;
				res.height = h_acc;
				pending_words.push_back(res);
				col_cnt = '0;
				row_cnt = '0;
				px_byte = '0;
				ph = (w_acc == '0 || h_acc == '0) ? PH_MAGIC : PH_PIXELS;
				mg_idx = '0;
				mg_bad = 1'b0;
			end
		end
		PH_PIXELS: begin
			if (px_byte == 2'd0) begin
				r_hold = b;
				px_byte = 2'd1;
			end else if (px_byte == 2'd1) begin
				g_hold = b;
				px_byte = 2'd2;
			end else begin
				px_byte = 2'd0;
				done = (c_next >= 32'(w_acc)) && (r_next >= 32'(h_acc));
				res.kind = KIND_PIXEL;
				res.red = r_hold;
				res.green = g_hold;
				res.blue = b;
				res.alpha = alpha_reg;
				res.column = col_cnt;
				res.row = row_cnt;
				res.width = w_acc;
				res.height = h_acc;
				res.last = done;
				pending_words.push_back(res);
				if (done) begin
					ph = PH_MAGIC;
					mg_idx = '0;
					mg_bad = 1'b0;
					col_cnt = '0;
					row_cnt = '0;
				end else if (c_next >= 32'(w_acc)) begin
					col_cnt = '0;
					row_cnt = row_cnt + 1'b1;
				end else begin
					col_cnt = col_cnt + 1'b1;
				end
			end
		end
		default: begin
			if ((mg_idx == 2'd0 && b != CH_P) || (mg_idx == 2'd1 && b != CH_SIX))
				mg_bad = 1'b1;
			if (mg_idx < MAGIC_LAST_IDX) begin
				mg_idx = mg_idx + 1'b1;
			end else begin
				mg_idx = '0;
				if (mg_bad) begin
					mg_bad = 1'b0;
					res.kind = KIND_BAD_MAGIC;
					pending_words.push_back(res);
				end else begin
					w_acc = '0;
					h_acc = '0;
					num_closed = 1'b0;
					ph = PH_FIRST;
				end
			end
		end
		endcase
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf("kind=%0d rgba=%02h%02h%02h%02h col=%0d row=%0d dim=%0dx%0d last=%0b",
			r.kind, r.red, r.green, r.blue, r.alpha, r.column, r.row, r.width, r.height,
			r.last);
	endfunction

	function automatic logic [7:0] rand_text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_LF);
		return b;
	endfunction

	// a byte that ends a number without being a delimiter
	function automatic logic [7:0] rand_junk_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_LF);
		return b;
	endfunction

	// called and returns at a falling edge; valid is left high between words of a burst
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = idle_on ? $urandom_range(6) : 0;
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
		n_bytes++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic send_maxval_line();
		if ($urandom_range(1)) begin
			send_text("255");
		end else begin
			repeat ($urandom_range(3))
				push_byte(rand_text_byte());
		end
		push_byte(CH_LF);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_alpha(input logic [7:0] a);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		alpha_reg = a;
	endtask

	task automatic send_image();
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		string       wtxt;
		string       htxt;
		pick = $urandom_range(19);
		if (pick < 14) begin
			w = $urandom_range(1, 5);
			h = $urandom_range(1, 4);
		end else if (pick < 17) begin
			w = 1;
			h = $urandom_range(2, 10);
		end else if (pick < 19) begin
			w = $urandom_range(6, 16);
			h = $urandom_range(1, 2);
		end else begin
			w = $urandom_range(20, 40);
			h = 2;
		end
		wtxt = $sformatf("%0d", w);
		htxt = $sformatf("%0d", h);
		if ($urandom_range(3) == 0)
			wtxt = {"0", wtxt};
		if ($urandom_range(3) == 0)
			htxt = {"00", htxt};
		push_byte(CH_P);
		push_byte(CH_SIX);
		push_byte(8'($urandom_range(255)));
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				push_byte(CH_HASH);
				repeat ($urandom_range(4))
					push_byte(rand_text_byte());
				push_byte(CH_LF);
			end
		end
		send_text(wtxt);
		// trailing junk closes the number, digits after it are dropped
		if ($urandom_range(4) == 0) begin
			push_byte(rand_junk_byte());
			push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
		end
		push_byte(CH_SPACE);
		send_text(htxt);
		if ($urandom_range(4) == 0) begin
			push_byte(rand_junk_byte());
			push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
		end
		push_byte(CH_LF);
		send_maxval_line();
		repeat (w * h * 3)
			push_byte(8'($urandom_range(255)));
		n_images++;
	endtask

	// header with one zero or empty dimension and the other anything up to seven digits
	task automatic send_empty_header();
		string big;
		string zero;
		big = $sformatf("%0d", $urandom_range(0, 9999999));
		if ($urandom_range(1))
			zero = "";
		else
			zero = "0";
		push_byte(CH_P);
		push_byte(CH_SIX);
		push_byte(8'($urandom_range(255)));
		if ($urandom_range(1)) begin
			// first width byte is never a delimiter, so an empty width needs two spaces
			if (zero.len() == 0)
				push_byte(CH_SPACE);
			send_text(zero);
			push_byte(CH_SPACE);
			send_text(big);
		end else begin
			send_text(big);
			push_byte(CH_SPACE);
			send_text(zero);
		end
		push_byte(CH_LF);
		send_maxval_line();
	endtask

	task automatic send_bad_magic();
		logic [7:0] b0;
		logic [7:0] b1;
		b0 = $urandom_range(1) ? CH_P : 8'($urandom_range(255));
		b1 = 8'($urandom_range(255));
		if (b0 == CH_P && b1 == CH_SIX)
			b1 = ~CH_SIX;
		push_byte(b0);
		push_byte(b1);
		push_byte(8'($urandom_range(255)));
	endtask

	task automatic test_bad_magic();
		push_byte(8'hFF);
		push_byte(CH_SIX);
		push_byte(8'h00);
		send_text("PQx");
	endtask

	task automatic test_empty_dims();
		send_text("P6");
		push_byte(8'h00);
		send_text("  \n");
		push_byte(8'hFF);
		push_byte(CH_LF);
	endtask

	task automatic test_number_rules();
		// comment line, width overflow, digit after a non-digit, zero height
		send_text("P6##\n70000x9 0\n\n");
	endtask

	task automatic test_pixel_image();
		send_text("P6A1 2\n\n");
		repeat (3) push_byte(8'h00);
		repeat (3) push_byte(8'hFF);
	endtask

	task automatic test_random_streams(input int unsigned n_target, input int unsigned stall,
			input bit idle);
		int unsigned start;
		int unsigned pick;
		stall_pct = stall;
		idle_on = idle;
		start = n_bytes;
		while (n_bytes - start < n_target) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_image();
			else if (pick < 87)
				send_bad_magic();
			else
				send_empty_header();
		end
	endtask

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_now = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			stall_run = $urandom_range(1, 5);
		end
		stall_run--;
		out_stall <= stall_now;
	end

	always @(posedge clk) begin : chk_results
		result_t seen;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{kind_t'(result_kind), red, green, blue, alpha, column, row,
				image_width, image_height, last_pixel};
			if (pending_words.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected word: %s", fmt_result(seen));
			end else begin
				want = pending_words.pop_front();
				if (seen !== want) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("mismatch  exp: %s", fmt_result(want));
						$display("          got: %s", fmt_result(seen));
					end
				end else if (want.kind == KIND_PIXEL) begin
					n_pixels++;
				end else if (want.kind == KIND_HEADER) begin
					n_headers++;
				end else begin
					n_bad++;
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timed out after %0d cycles", cycle_cnt);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		stall_pct = 25;
		idle_on = 1'b1;
		test_bad_magic();
		test_empty_dims();
		test_number_rules();
		test_pixel_image();

		set_alpha(8'h00);
		test_random_streams(200, 30, 1'b1);
		mid_alpha = $urandom_range(1, 254);
		set_alpha(8'(mid_alpha));
		test_random_streams(250, 0, 1'b0);
		set_alpha(8'hFF);
		test_random_streams(200, 50, 1'b1);
		drain_results();

		$display("%0d bytes in, %0d images; checked %0d pixels, %0d headers, %0d bad magic",
			n_bytes, n_images, n_pixels, n_headers, n_bad);
		$display("alpha 255, 0, %0d, 255 with idle and stall phases; %0d mismatches",
			mid_alpha, err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ppmd_pkg.sv
rtl/ppmd_parser.sv
rtl/ppm_p6_stream_decoder_core.sv
tb/sv/tb_ppm_p6_stream_decoder_core.sv
